/* hw/rtl/cvpp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cvpp_pkg;

    localparam int unsigned PIX_W  = 19;
    localparam int unsigned RGB_W  = 24;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW = $clog2(FIFO_DEPTH);

    localparam logic [RGB_W-1:0] BYTE_LSB_CLR = 24'hfefefe;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAMMA_MODE    = 3'd0,
        CFG_SCANLINE_MODE = 3'd1,
        CFG_BLUR_MODE     = 3'd2,
        CFG_INTERLACED    = 3'd3,
        CFG_ODD_FIELD     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_upper;
        logic [PIX_W-1:0] pixel_lower;
        logic             line_end;
    } t_in;

    typedef struct packed {
        logic [RGB_W-1:0] rgb_upper;
        logic [RGB_W-1:0] rgb_lower;
        logic             last_of_line;
    } t_out;

    typedef struct packed {
        logic gamma_mode;
        logic scanline_mode;
        logic blur_mode;
        logic interlaced;
        logic odd_field;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic line_end;
    } t_stage;

    function automatic logic [7:0] ramp(input logic [4:0] n);
        logic [7:0] v;
        unique case (n)
            5'd0:  v = 8'h00;
            5'd1:  v = 8'h01;
            5'd2:  v = 8'h03;
            5'd3:  v = 8'h06;
            5'd4:  v = 8'h0a;
            5'd5:  v = 8'h0f;
            5'd6:  v = 8'h15;
            5'd7:  v = 8'h1c;
            5'd8:  v = 8'h24;
            5'd9:  v = 8'h2d;
            5'd10: v = 8'h37;
            5'd11: v = 8'h42;
            5'd12: v = 8'h4e;
            5'd13: v = 8'h5b;
            5'd14: v = 8'h69;
            5'd15: v = 8'h78;
            5'd16: v = 8'h88;
            5'd17: v = 8'h90;
            5'd18: v = 8'h98;
            5'd19: v = 8'ha0;
            5'd20: v = 8'ha8;
            5'd21: v = 8'hb0;
            5'd22: v = 8'hb8;
            5'd23: v = 8'hc0;
            5'd24: v = 8'hc8;
            5'd25: v = 8'hd0;
            5'd26: v = 8'hd8;
            5'd27: v = 8'he0;
            5'd28: v = 8'he8;
            5'd29: v = 8'hf0;
            5'd30: v = 8'hf8;
            default: v = 8'hff;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] chan(input logic [4:0] n, input logic [3:0] l,
                                        input logic g);
        logic [7:0]  v;
        logic [4:0]  lp1;
        logic [12:0] p;
        v   = g ? ramp(n) : {n, n[4:2]};
        lp1 = {1'b0, l} + 5'd1;
        p   = {8'd0, lp1} * {5'd0, v};
        return (l == 4'd0) ? {5'd0, v[7:5]} : p[11:4];
    endfunction

    function automatic logic [RGB_W-1:0] dim(input logic [RGB_W-1:0] c);
        return (c & BYTE_LSB_CLR) >> 1;
    endfunction

    function automatic logic [RGB_W-1:0] avg(input logic [RGB_W-1:0] a,
                                             input logic [RGB_W-1:0] b);
        return (a & b) + (((a ^ b) & BYTE_LSB_CLR) >> 1);
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/cvpp_lane.sv */
`timescale 1ns / 1ps
`default_nettype none

module cvpp_lane (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic                      i_gamma_mode,
    input  wire logic [cvpp_pkg::PIX_W-1:0] i_pixel,
    output logic      [cvpp_pkg::RGB_W-1:0] o_rgb
);

    logic [3:0]                 w_l;
    logic [cvpp_pkg::RGB_W-1:0] n_rgb;
    logic [cvpp_pkg::RGB_W-1:0] r_rgb;

    always_comb begin
        w_l   = i_pixel[18:15];
        n_rgb = {cvpp_pkg::chan(i_pixel[4:0],   w_l, i_gamma_mode),
                 cvpp_pkg::chan(i_pixel[9:5],   w_l, i_gamma_mode),
                 cvpp_pkg::chan(i_pixel[14:10], w_l, i_gamma_mode)};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rgb <= n_rgb;
        end
    end

    assign o_rgb = r_rgb;

endmodule

`default_nettype wire

/* hw/rtl/cvpp_merge.sv */
`timescale 1ns / 1ps
`default_nettype none

module cvpp_merge (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire cvpp_pkg::t_cfg             i_cfg,
    input  wire cvpp_pkg::t_stage           i_stage,
    input  wire logic [cvpp_pkg::RGB_W-1:0] i_up,
    input  wire logic [cvpp_pkg::RGB_W-1:0] i_lo,
    output logic                            o_take,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output cvpp_pkg::t_out                  o_out_data
);

    localparam int unsigned AW = cvpp_pkg::FIFO_AW;

    logic [cvpp_pkg::RGB_W-1:0] w_up;
    logic [cvpp_pkg::RGB_W-1:0] w_lo_base;
    logic [cvpp_pkg::RGB_W-1:0] w_lo;
    logic                       w_dim_up;

    logic [cvpp_pkg::RGB_W-1:0] r_held_up;
    logic [cvpp_pkg::RGB_W-1:0] r_held_lo;
    logic                       r_held_valid;
    logic                       n_held_valid;
    logic                       w_hold_cur;

    cvpp_pkg::t_out w_res_a;
    cvpp_pkg::t_out w_res_b;
    logic [1:0]     w_npush;
    logic           w_pop;

    cvpp_pkg::t_out r_q [cvpp_pkg::FIFO_DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [AW:0]    r_count;
    logic [AW-1:0]  n_wr;
    logic [AW-1:0]  n_rd;
    logic [AW:0]    n_count;
    logic [AW-1:0]  w_wr_next;

    // row selection and scanline dimming
    always_comb begin
        w_dim_up  = i_cfg.scanline_mode && i_cfg.interlaced && i_cfg.odd_field;
        w_lo_base = i_cfg.interlaced ? i_lo : i_up;
        w_up      = w_dim_up ? cvpp_pkg::dim(i_up) : i_up;
        w_lo      = (i_cfg.scanline_mode && !w_dim_up) ? cvpp_pkg::dim(w_lo_base)
                                                        : w_lo_base;
    end

    assign o_take = i_stage.valid && (r_count <= (AW+1)'(cvpp_pkg::FIFO_DEPTH - 2));
    assign w_pop  = o_out_valid && !i_out_stall;

    // results of one beat: held pixel (under blur, its average with the current one) first, then the current one
    always_comb begin
        w_res_a      = '{rgb_upper: w_up, rgb_lower: w_lo, last_of_line: i_stage.line_end};
        w_res_b      = w_res_a;
        w_npush      = 2'd0;
        w_hold_cur   = 1'b0;
        n_held_valid = r_held_valid;
        if (o_take) begin
            if (!i_cfg.blur_mode) begin
                n_held_valid = 1'b0;
                if (r_held_valid) begin
                    w_res_a = '{rgb_upper: r_held_up, rgb_lower: r_held_lo,
                                last_of_line: 1'b0};
                    w_npush = 2'd2;
                end else begin
                    w_npush = 2'd1;
                end
            end else begin
                if (r_held_valid) begin
                    w_res_a = '{rgb_upper: cvpp_pkg::avg(r_held_up, w_up),
                                rgb_lower: cvpp_pkg::avg(r_held_lo, w_lo),
                                last_of_line: 1'b0};
                    w_npush = i_stage.line_end ? 2'd2 : 2'd1;
                end else begin
                    w_npush = i_stage.line_end ? 2'd1 : 2'd0;
                end
                w_res_b.last_of_line = 1'b1;
                n_held_valid = !i_stage.line_end;
                w_hold_cur   = !i_stage.line_end;
            end
        end
    end

    always_comb begin
        w_wr_next = r_wr + AW'(1);
        n_wr      = r_wr + AW'(w_npush);
        n_rd      = w_pop ? r_rd + AW'(1) : r_rd;
        n_count   = r_count + (AW+1)'(w_npush) - (AW+1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_wr         <= '0;
            r_rd         <= '0;
            r_count      <= '0;
        end else begin
            r_held_valid <= n_held_valid;
            r_wr         <= n_wr;
            r_rd         <= n_rd;
            r_count      <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hold_cur) begin
            r_held_up <= w_up;
            r_held_lo <= w_lo;
        end
        if (w_npush != 2'd0) begin
            r_q[r_wr] <= w_res_a;
        end
        if (w_npush == 2'd2) begin
            r_q[w_wr_next] <= w_res_b;
        end
    end

    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_q[r_rd];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(cvpp_pkg::FIFO_DEPTH))
        else $error("output queue overfilled");

    a_blur_off_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && !i_cfg.blur_mode) |=> !r_held_valid)
        else $error("pixel still held with blur off");

    a_line_end_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_stage.line_end) |=> !r_held_valid)
        else $error("pixel held across line end");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && r_count == (AW+1)'(1) && w_npush == 2'd0) |=> !o_out_valid)
        else $error("output valid after last beat drained");

endmodule

`default_nettype wire

/* hw/rtl/console_video_pixel_pipeline.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Valid        | Stall        | Data / fields
// ---------+--------------+--------------+------------------------------------------
// input    | i_in_valid   | o_in_stall   | i_in_data: pixel_upper, pixel_lower, line_end
// output   | o_out_valid  | i_out_stall  | o_out_data: rgb_upper, rgb_lower, last_of_line
// config   | i_cfg_we     | -            | i_cfg_idx, i_cfg_data
//
// One input beat per cycle unless o_in_stall is high; each beat's result passes the
// conversion lane registers, then the four-entry output queue.
// A line-end beat under blur yields two results; the queue absorbs the burst, and the
// next line's first beat yields none; one per cycle is sustained while i_out_stall is low.
// Input stalls only when the queue holds more than two results (downstream stalling).
// Synchronous active-low reset clears the configuration, the blur hold and the queue.

module console_video_pixel_pipeline (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire cvpp_pkg::t_in                   i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output cvpp_pkg::t_out                       o_out_data,
    input  wire logic                            i_cfg_we,
    input  wire logic [cvpp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic                            i_cfg_data
);

    cvpp_pkg::t_cfg   r_cfg;
    cvpp_pkg::t_stage r_stage;
    logic             w_load;
    logic             w_take;
    logic [cvpp_pkg::RGB_W-1:0] w_up;
    logic [cvpp_pkg::RGB_W-1:0] w_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cvpp_pkg::CFG_GAMMA_MODE:    r_cfg.gamma_mode    <= i_cfg_data;
                cvpp_pkg::CFG_SCANLINE_MODE: r_cfg.scanline_mode <= i_cfg_data;
                cvpp_pkg::CFG_BLUR_MODE:     r_cfg.blur_mode     <= i_cfg_data;
                cvpp_pkg::CFG_INTERLACED:    r_cfg.interlaced    <= i_cfg_data;
                cvpp_pkg::CFG_ODD_FIELD:     r_cfg.odd_field     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_stall = r_stage.valid && !w_take;
    assign w_load     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else if (w_load) begin
            r_stage.valid    <= 1'b1;
            r_stage.line_end <= i_in_data.line_end;
        end else if (w_take) begin
            r_stage.valid <= 1'b0;
        end
    end

    cvpp_lane u_lane_upper (
        .i_clk        (i_clk),
        .i_en         (w_load),
        .i_gamma_mode (r_cfg.gamma_mode),
        .i_pixel      (i_in_data.pixel_upper),
        .o_rgb        (w_up)
    );

    cvpp_lane u_lane_lower (
        .i_clk        (i_clk),
        .i_en         (w_load),
        .i_gamma_mode (r_cfg.gamma_mode),
        .i_pixel      (i_in_data.pixel_lower),
        .o_rgb        (w_lo)
    );

    cvpp_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_stage     (r_stage),
        .i_up        (w_up),
        .i_lo        (w_lo),
        .o_take      (w_take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
